FILE: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types for the chunked body decoder
// Parser phases, error codes, framing bytes and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_DATA_CRLF = 2'd1,
    ERR_BAD_SIZE  = 2'd2,
    ERR_SIZE_LONG = 2'd3
  } err_e;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // one input word as it sits in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
  } item_t;

  // one decoded word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_done;
    err_e       error_code;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t r;
    r.is_hex = 1'b1;
    r.value  = 4'd0;
    if (b >= "0" && b <= "9") begin
      r.value = 4'(b - 8'h30);
    end else if (b >= "a" && b <= "f") begin
      r.value = 4'(b - 8'h57);
    end else if (b >= "A" && b <= "F") begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.is_hex = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hcbd_if.sv
// ----------------------------------------------------------------------------
// hcbd_if: stream interfaces of the chunked body decoder
// Input channel carries raw body bytes, output channel decoded words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_body;

  modport source (output valid, output data_byte, output start_of_body, input ready);
  modport sink   (input valid, input data_byte, input start_of_body, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       body_done;
  logic [1:0] error_code;

  modport source (output valid, output payload_byte, output payload_valid,
                  output body_done, output error_code, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input body_done, input error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcbd_in_reg.sv
// ----------------------------------------------------------------------------
// hcbd_in_reg: input register
// Holds one accepted word until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic          pop_i,
  input  wire hcbd_pkg::item_t item_i,
  output hcbd_pkg::item_t    item_o,
  output logic               valid_o
);

  hcbd_pkg::item_t item_q;
  logic            valid_q, valid_d;

  always_comb begin
    if (push_i) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/hcbd_parser.sv
// ----------------------------------------------------------------------------
// hcbd_parser: chunk framing state machine
// Parses size lines, counts payload bytes and checks the CR LF framing.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire hcbd_pkg::item_t item_i,
  output hcbd_pkg::result_t    result_o
);

  localparam int MaxDigits = SIZE_BITS / 4;
  localparam int CntW      = $clog2(MaxDigits + 1);

  hcbd_pkg::phase_e phase_q, phase_d, phase_c;
  hcbd_pkg::err_e   err_q, err_d, err_c;
  logic [SIZE_BITS-1:0] left_q, left_d, left_c;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_c;
  hcbd_pkg::hex_t       hex;
  logic [7:0]           b;

  assign b   = item_i.data_byte;
  assign hex = hcbd_pkg::hex_decode(b);

  // start of body clears the parser before the byte is looked at
  always_comb begin
    if (item_i.start_of_body) begin
      phase_c = hcbd_pkg::PH_SIZE;
      err_c   = hcbd_pkg::ERR_NONE;
      left_c  = '0;
      cnt_c   = '0;
    end else begin
      phase_c = phase_q;
      err_c   = err_q;
      left_c  = left_q;
      cnt_c   = cnt_q;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_c;
    err_d   = err_c;
    left_d  = left_c;
    cnt_d   = cnt_c;
    unique case (phase_c)
      hcbd_pkg::PH_SIZE: begin
        if (hex.is_hex) begin
          if (cnt_c >= CntW'(MaxDigits)) begin
            phase_d = hcbd_pkg::PH_ERROR;
            err_d   = hcbd_pkg::ERR_SIZE_LONG;
          end else begin
            left_d = {left_c[SIZE_BITS-5:0], hex.value};
            cnt_d  = cnt_c + CntW'(1);
          end
        end else if (cnt_c == '0) begin
          phase_d = hcbd_pkg::PH_ERROR;
          err_d   = hcbd_pkg::ERR_BAD_SIZE;
        end else if (b == hcbd_pkg::BYTE_CR) begin
          phase_d = hcbd_pkg::PH_SIZE_LF;
        end else begin
          phase_d = hcbd_pkg::PH_EXT;
        end
      end
      hcbd_pkg::PH_EXT: begin
        if (b == hcbd_pkg::BYTE_CR) begin
          phase_d = hcbd_pkg::PH_SIZE_LF;
        end
      end
      hcbd_pkg::PH_SIZE_LF: begin
        if (b != hcbd_pkg::BYTE_LF) begin
          phase_d = hcbd_pkg::PH_ERROR;
          err_d   = hcbd_pkg::ERR_BAD_SIZE;
        end else if (left_c == '0) begin
          phase_d = hcbd_pkg::PH_DONE;
        end else begin
          phase_d = hcbd_pkg::PH_DATA;
        end
      end
      hcbd_pkg::PH_DATA: begin
        left_d = left_c - SIZE_BITS'(1);
        if (left_c == SIZE_BITS'(1)) begin
          phase_d = hcbd_pkg::PH_DATA_CR;
        end
      end
      hcbd_pkg::PH_DATA_CR: begin
        if (b == hcbd_pkg::BYTE_CR) begin
          phase_d = hcbd_pkg::PH_DATA_LF;
        end else begin
          phase_d = hcbd_pkg::PH_ERROR;
          err_d   = hcbd_pkg::ERR_DATA_CRLF;
        end
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (b == hcbd_pkg::BYTE_LF) begin
          phase_d = hcbd_pkg::PH_SIZE;
          left_d  = '0;
          cnt_d   = '0;
        end else begin
          phase_d = hcbd_pkg::PH_ERROR;
          err_d   = hcbd_pkg::ERR_DATA_CRLF;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs; error code is the one left after this byte
  always_comb begin
    result_o.payload_byte  = 8'h00;
    result_o.payload_valid = 1'b0;
    result_o.body_done     = 1'b0;
    result_o.error_code    = err_d;
    unique case (phase_c)
      hcbd_pkg::PH_DATA: begin
        result_o.payload_byte  = b;
        result_o.payload_valid = 1'b1;
      end
      hcbd_pkg::PH_SIZE_LF: begin
        result_o.body_done = (b == hcbd_pkg::BYTE_LF) && (left_c == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hcbd_pkg::PH_SIZE;
      err_q   <= hcbd_pkg::ERR_NONE;
      left_q  <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: chunked transfer coding body decoder
// Turns a chunked HTTP body byte stream into payload bytes plus status.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  in_i    | in  | valid/ready   | data_byte[7:0], start_of_body
//  out_o   | out | valid/ready   | payload_byte[7:0], payload_valid,
//          |     |               | body_done, error_code[1:0]
//
//  One word in, one word out, one word per cycle sustained while the output
//  is not stalled. Path: input register, then parser into output register.
//  The parser state is updated with each advanced byte, so every byte follows the
//  previous one directly.
//  Asynchronous active-low reset clears parser state and both valid flags.
//  A stalled output holds its word; the input register keeps taking a word
//  while the output waits only if it is itself empty.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o
);

  hcbd_pkg::item_t   in_item, s1_item;
  hcbd_pkg::result_t res, res_q;
  logic              s1_valid, advance, accept;
  logic              out_valid_q, out_valid_d;

  assign in_item.data_byte     = in_i.data_byte;
  assign in_item.start_of_body = in_i.start_of_body;

  assign advance    = s1_valid && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid || advance;
  assign accept     = in_i.valid && in_i.ready;

  hcbd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .pop_i   (advance),
    .item_i  (in_item),
    .item_o  (s1_item),
    .valid_o (s1_valid)
  );

  hcbd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item),
    .result_o (res)
  );

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_byte  = res_q.payload_byte;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.body_done     = res_q.body_done;
  assign out_o.error_code    = res_q.error_code;

endmodule

`default_nettype wire

FILE: rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker: port-level checks for the chunked body decoder
// Watches the output channel and the consistency of decoded words.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] payload_byte_i,
  input wire logic       payload_valid_i,
  input wire logic       body_done_i,
  input wire logic [1:0] error_code_i
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i)
      && $stable(payload_valid_i) && $stable(body_done_i) && $stable(error_code_i))
    else $error("output word changed while stalled");

  // non-payload words carry a zero byte
  a_pay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !payload_valid_i |-> payload_byte_i == 8'h00)
    else $error("payload byte set on non-payload word");

  // payload only flows while no error is latched
  a_pay_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && payload_valid_i |-> error_code_i == hcbd_pkg::ERR_NONE && !body_done_i)
    else $error("payload word with error or done");

  // end of body only on a clean stream
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && body_done_i |-> error_code_i == hcbd_pkg::ERR_NONE)
    else $error("body done with error latched");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .payload_byte_i  (out_o.payload_byte),
  .payload_valid_i (out_o.payload_valid),
  .body_done_i     (out_o.body_done),
  .error_code_i    (out_o.error_code)
);

`default_nettype wire
